FILE: hdl/cfr_pkg.sv
// Package for the serial control frame reassembler.
// Holds the request and response transfer types and the framing byte codes.
// Depends on nothing; imported by civ_frame_reassembler.
`default_nettype none

package cfr_pkg;

   // Largest frame, preambles and terminator included, that the block keeps.
   localparam int MAX_FRAME_BYTES_DEF = 64;

   // Width of the byte position field on the response side.
   localparam int BYTE_INDEX_W = 6;

   // Framing byte codes.
   localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
   localparam logic [7:0] END_BYTE      = 8'hFD;
   localparam logic [7:0] ALT_END_BYTE  = 8'hFC;

   // Request kinds.
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_TIMEOUT = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [7:0]              frame_byte;
      logic [BYTE_INDEX_W-1:0] byte_index;
      logic                    last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/civ_frame_reassembler.sv
// Serial control frame reassembler, top level; uses types and codes from cfr_pkg.
// Bytes from a serial link come in one per request transfer, together with timeout
// events. While hunting, the block waits for two 0xFE preamble bytes in a row; a
// lone 0xFE followed by any other byte starts nothing. Inside a frame every byte is
// written to a frame memory of MAX_FRAME_BYTES entries. On a 0xFD or 0xFC terminator
// the whole frame, both preambles first and the terminator last, is sent out as one
// response transfer per byte with its position and a last flag, and the block
// returns to hunting. A byte that is not a terminator and fills the frame to the
// cap drops the frame without any response. A timeout event clears the framing
// state in any case. After a timeout or a byte that is not a terminator, the block
// is ready again on the next cycle. A completed frame is replayed through the
// single read port of the frame memory, each byte in a read state that addresses
// the memory and then a show state that presents the registered data, which the
// response side can stall; request stall stays high during the replay.
`default_nettype none

module civ_frame_reassembler #(
   parameter int MAX_FRAME_BYTES = cfr_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  cfr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output cfr_pkg::rsp_type rsp_data
);
   import cfr_pkg::*;

   localparam int AW = $clog2(MAX_FRAME_BYTES);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_SHOW = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic          in_frame_ff, in_frame_in;
   logic          saw_pre_ff, saw_pre_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] last_idx_ff, last_idx_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]    rd_data_ff;
   logic [7:0]    frame_mem [MAX_FRAME_BYTES];

   logic req_xfer;
   logic is_term;
   logic store_byte;

   // The block only takes a request while no frame is being replayed.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign is_term    = (req_data.byte_value == END_BYTE) ||
                       (req_data.byte_value == ALT_END_BYTE);
   assign store_byte = req_xfer && (req_data.kind == KIND_BYTE) && in_frame_ff;

   // Sequencer and framing state.
   always_comb begin
      state_in    = state_ff;
      in_frame_in = in_frame_ff;
      saw_pre_in  = saw_pre_ff;
      fill_in     = fill_ff;
      last_idx_in = last_idx_ff;
      idx_in      = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_data.kind == KIND_TIMEOUT) begin
                  in_frame_in = 1'b0;
                  saw_pre_in  = 1'b0;
                  fill_in     = '0;
               end else if (!in_frame_ff) begin
                  // Hunting: two preambles in a row open a frame.
                  if (req_data.byte_value != PREAMBLE_BYTE) begin
                     saw_pre_in = 1'b0;
                  end else if (!saw_pre_ff) begin
                     saw_pre_in = 1'b1;
                  end else begin
                     saw_pre_in  = 1'b0;
                     in_frame_in = 1'b1;
                     fill_in     = AW'(2);
                  end
               end else if (is_term) begin
                  // The terminator sits at the current fill position.
                  last_idx_in = fill_ff;
                  idx_in      = '0;
                  in_frame_in = 1'b0;
                  fill_in     = '0;
                  state_in    = ST_READ;
               end else if (fill_ff == AW'(MAX_FRAME_BYTES - 1)) begin
                  // This byte fills the frame to the cap: drop it silently.
                  in_frame_in = 1'b0;
                  fill_in     = '0;
               end else begin
                  fill_in = fill_ff + AW'(1);
               end
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (!rsp_stall) begin
               if (idx_ff == last_idx_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + AW'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_frame_ff <= 1'b0;
         saw_pre_ff  <= 1'b0;
         fill_ff     <= '0;
         idx_ff      <= '0;
         last_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         in_frame_ff <= in_frame_in;
         saw_pre_ff  <= saw_pre_in;
         fill_ff     <= fill_in;
         idx_ff      <= idx_in;
         last_idx_ff <= last_idx_in;
      end
   end

   // Frame memory. Positions zero and one are the preambles, which are never
   // written; the response side supplies them directly.
   always_ff @(posedge clock) begin
      if (store_byte) begin
         frame_mem[fill_ff] <= req_data.byte_value;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         rd_data_ff <= frame_mem[idx_ff];
      end
   end

   // Response payload comes straight from registers, so it holds while stalled.
   assign rsp_valid           = (state_ff == ST_SHOW);
   assign rsp_data.frame_byte = (idx_ff < AW'(2)) ? PREAMBLE_BYTE : rd_data_ff;
   assign rsp_data.byte_index = BYTE_INDEX_W'(idx_ff);
   assign rsp_data.last       = (idx_ff == last_idx_ff);

`ifndef SYNTH
   // No request is taken while a frame is being replayed.
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken during frame replay");

   // The final byte of a frame returns the block to hunting.
   a_last_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.last |=> !rsp_valid && !req_stall)
      else $error("frame replay did not end after last byte");

   // Bytes of a frame come out at consecutive positions.
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> !rsp_valid ##1
      (rsp_valid && rsp_data.byte_index ==
       BYTE_INDEX_W'($past(rsp_data.byte_index, 2) + 1'b1)))
      else $error("frame byte position skipped");

   // Every frame opens with two preamble bytes.
   a_preambles_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.byte_index == '0 || rsp_data.byte_index == 6'd1)
      |-> rsp_data.frame_byte == PREAMBLE_BYTE && !rsp_data.last)
      else $error("frame does not open with preambles");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_civ_frame_reassembler.sv
// Testbench for civ_frame_reassembler: random and directed byte streams with timeouts.
// A replay checker class predicts every frame byte and checks each response transfer.
// Depends on cfr_pkg and the civ_frame_reassembler RTL only.
`default_nettype none

class frame_replay_checker;
   // Framing state as the block should hold it.
   bit          in_frame;
   bit          saw_one_preamble;
   logic [7:0]  frame_mem [cfr_pkg::MAX_FRAME_BYTES_DEF];
   int unsigned fill;
   // Frame bytes still owed by the block, oldest first.
   cfr_pkg::rsp_type replay_bytes [$];

   function void clear_framing();
      in_frame         = 1'b0;
      saw_one_preamble = 1'b0;
      fill             = 0;
   endfunction

   // Called once per accepted request transfer.
   function void take_request(cfr_pkg::req_type req);
      cfr_pkg::rsp_type rsp;
      if (req.kind == cfr_pkg::KIND_TIMEOUT) begin
         clear_framing();
         return;
      end
      if (!in_frame) begin
         if (req.byte_value != cfr_pkg::PREAMBLE_BYTE) begin
            saw_one_preamble = 1'b0;
         end else if (!saw_one_preamble) begin
            saw_one_preamble = 1'b1;
         end else begin
            saw_one_preamble = 1'b0;
            in_frame         = 1'b1;
            frame_mem[0]     = cfr_pkg::PREAMBLE_BYTE;
            frame_mem[1]     = cfr_pkg::PREAMBLE_BYTE;
            fill             = 2;
         end
         return;
      end
      if (fill >= cfr_pkg::MAX_FRAME_BYTES_DEF) begin
         clear_framing();
         return;
      end
      frame_mem[fill] = req.byte_value;
      fill++;
      if (req.byte_value == cfr_pkg::END_BYTE || req.byte_value == cfr_pkg::ALT_END_BYTE) begin
         for (int i = 0; i < fill; i++) begin
            rsp.frame_byte = frame_mem[i];
            rsp.byte_index = 6'(i);
            rsp.last       = (i + 1 == fill);
            replay_bytes   = {replay_bytes, rsp};
         end
         clear_framing();
      end else if (fill >= cfr_pkg::MAX_FRAME_BYTES_DEF) begin
         clear_framing();
      end
   endfunction

   // Returns 1 and a description when the response transfer is wrong.
   function bit check_replay_byte(cfr_pkg::rsp_type got, output string why);
      cfr_pkg::rsp_type want;
      why = "";
      if (replay_bytes.size() == 0) begin
         why = $sformatf("byte %02h at index %0d arrived with no frame byte owed",
                         got.frame_byte, got.byte_index);
         return 1'b1;
      end
      want = replay_bytes.pop_front();
      if (got.frame_byte !== want.frame_byte)
         why = {why, $sformatf(" frame_byte %02h/%02h", got.frame_byte, want.frame_byte)};
      if (got.byte_index !== want.byte_index)
         why = {why, $sformatf(" byte_index %0d/%0d", got.byte_index, want.byte_index)};
      if (got.last !== want.last)
         why = {why, $sformatf(" last %b/%b", got.last, want.last)};
      if (why != "")
         why = $sformatf("frame byte %0d, got/wanted:%s", want.byte_index, why);
      return why != "";
   endfunction

   function int unsigned owed();
      return replay_bytes.size();
   endfunction
endclass

module tb_civ_frame_reassembler;
   import cfr_pkg::*;

   // Cycles without any transfer on either side before the run is declared hung.
   // The long receiver hold-off is the worst case and stays well below this.
   localparam int WATCHDOG_LIMIT = 1000;
   // The receiver stops taking frame bytes for this many cycles once, after
   // this many accepted response transfers, so the block backs up.
   localparam int HOLD_AT_RESULT = 100;
   localparam int HOLD_CYCLES    = 300;
   // Least number of request transfers to send, directed ones included.
   localparam int NUM_ITEMS      = 230;
   localparam int MAX_BODY       = MAX_FRAME_BYTES_DEF - 3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   wire req_fire = req_valid && !req_stall;
   wire rsp_fire = rsp_valid && !rsp_stall;

   frame_replay_checker replay_check;

   int  mismatches;
   int  rsp_accepted;
   int  rsp_hold;       // cycles the receiver still stalls
   bit  rsp_burst;      // receiver takes bytes back to back while set
   bit  req_burst;      // sender offers items back to back while set
   int  sent_items;

   civ_frame_reassembler #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES_DEF)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string why);
      $display("MISMATCH at %0t: %s", $realtime, why);
      mismatches++;
   endtask

   // One request transfer. The gap in front of it is drawn per item, and the
   // payload is held steady at the falling edge until a rising edge sees no
   // stall. Only then does the predictor learn about the item.
   task automatic send_item(input logic kind, input logic [7:0] value);
      req_type item;
      int      gap;
      item.kind       = kind;
      item.byte_value = value;
      gap = req_burst ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      replay_check.take_request(item);
      sent_items++;
   endtask

   task automatic send_byte(input logic [7:0] value);
      send_item(KIND_BYTE, value);
   endtask

   task automatic send_timeout();
      // The byte field is a don't-care on a timeout, so it carries noise.
      send_item(KIND_TIMEOUT, 8'($urandom_range(0, 255)));
   endtask

   // A body byte is anything but a terminator; preambles show up often so
   // that a 0xFE inside a frame is exercised.
   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      if ($urandom_range(0, 7) == 0)
         return PREAMBLE_BYTE;
      do b = 8'($urandom_range(0, 255)); while (b == END_BYTE || b == ALT_END_BYTE);
      return b;
   endfunction

   // Two preambles, a random body and a terminator. With a body of MAX_BODY
   // the frame exactly fills the store; one byte more drops the frame, and the
   // terminator after it is then just a stray byte while hunting.
   task automatic send_frame(input int body_len, input bit with_end);
      send_byte(PREAMBLE_BYTE);
      send_byte(PREAMBLE_BYTE);
      repeat (body_len) send_byte(body_byte());
      if (with_end)
         send_byte($urandom_range(0, 1) ? END_BYTE : ALT_END_BYTE);
   endtask

   // Response side: every accepted frame byte is checked against the oldest
   // owed byte. Sampling happens at the rising edge, where the block's
   // outputs still hold their values from before the edge.
   always @(posedge clock) begin
      string why;
      if (!reset && rsp_fire) begin
         if (replay_check.check_replay_byte(rsp_data, why))
            report_mismatch(why);
         rsp_accepted++;
         if (rsp_accepted == HOLD_AT_RESULT) begin
            rsp_hold = HOLD_CYCLES;
         end else begin
            if (rsp_accepted % 16 == 0)
               rsp_burst = ($urandom_range(0, 2) == 0);
            rsp_hold = rsp_burst ? 0 : $urandom_range(0, 9);
         end
      end
   end

   // The receiver stall changes only at the falling edge.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // The watchdog restarts whenever a transfer happens on either side.
   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || rsp_fire)
            idle = 0;
         else
            idle++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      int pick;
      int seq_no;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      rsp_stall    = 1'b0;
      rsp_hold     = 0;
      rsp_burst    = 1'b0;
      req_burst    = 1'b0;
      mismatches   = 0;
      rsp_accepted = 0;
      sent_items   = 0;
      replay_check = new;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part.
      // A timeout while hunting, with every byte bit set, does nothing.
      send_item(KIND_TIMEOUT, 8'hFF);
      // A lone preamble followed by another byte starts no frame.
      send_byte(PREAMBLE_BYTE);
      send_byte(8'h00);
      // Extreme body bytes inside a frame closed by the main terminator.
      send_byte(PREAMBLE_BYTE);
      send_byte(PREAMBLE_BYTE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(END_BYTE);
      // Three preambles in a row: the third is body. Closed by the other terminator.
      send_byte(PREAMBLE_BYTE);
      send_byte(PREAMBLE_BYTE);
      send_byte(PREAMBLE_BYTE);
      send_byte(ALT_END_BYTE);
      // Shortest frame: preambles and terminator only.
      send_byte(PREAMBLE_BYTE);
      send_byte(PREAMBLE_BYTE);
      send_byte(END_BYTE);
      // A timeout inside a frame throws it away; the terminator after it is stray.
      send_byte(PREAMBLE_BYTE);
      send_byte(PREAMBLE_BYTE);
      send_byte(8'h12);
      send_item(KIND_TIMEOUT, 8'h00);
      send_byte(END_BYTE);
      // A timeout between two preambles keeps them from pairing up.
      send_byte(PREAMBLE_BYTE);
      send_item(KIND_TIMEOUT, 8'hA5);
      send_byte(PREAMBLE_BYTE);
      send_byte(8'h55);

      // Random part, mostly well-formed frames with random content. The
      // largest frame and the dropped frame are forced early on and then
      // come back now and then.
      seq_no = 0;
      while (sent_items < NUM_ITEMS) begin
         req_burst = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (seq_no == 2 || pick < 2) begin
            send_frame(MAX_BODY, 1'b1);
         end else if (seq_no == 5 || pick < 4) begin
            send_frame(MAX_BODY + 1, 1'b1);
         end else if (pick < 70) begin
            send_frame($urandom_range(0, 8), 1'b1);
         end else if (pick < 80) begin
            // A frame cut short by a timeout.
            send_frame($urandom_range(0, 6), 1'b0);
            send_timeout();
         end else if (pick < 90) begin
            // Half a preamble, then a timeout or a body byte, which breaks it unless it is another preamble.
            send_byte(PREAMBLE_BYTE);
            if ($urandom_range(0, 1))
               send_timeout();
            else
               send_byte(body_byte());
         end else begin
            // Noise: raw bytes of any value and timeouts.
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 4) == 0)
                  send_timeout();
               else
                  send_byte(8'($urandom_range(0, 255)));
            end
         end
         seq_no++;
      end
      @(negedge clock);
      req_valid <= 1'b0;

      // Drain every owed frame byte, then leave room for anything stray.
      while (replay_check.owed() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
